// ===== rtl/quoted_token_splitter_unit_assert.svh =====
// Assertion macros shared by the checker of the quoted token splitter.
// Each macro takes a label, a clock, an active-low reset, a condition
// and the consequence that must hold when the condition is true.
`ifndef QUOTED_TOKEN_SPLITTER_UNIT_ASSERT_SVH
`define QUOTED_TOKEN_SPLITTER_UNIT_ASSERT_SVH

// Consequence holds in the same cycle as the condition.
`define QTS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("quoted token splitter check failed");

// Consequence holds in the cycle after the condition.
`define QTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("quoted token splitter check failed");

`endif

// ===== rtl/qts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Quoted token splitter package
// Shared constants and result and queue entry types.
// ----------------------------------------------------------------------------
package qts_pkg;

	// Longest token is TOKEN_LIMIT-1 characters.
	localparam int TOKEN_LIMIT = 1024;
	localparam int LEN_W = $clog2(TOKEN_LIMIT);

	// Extra space and delimiter slots; the registers hold at most four bytes.
	localparam int EXTRA_CHAR_SLOTS = 4;
	localparam int MATCH_SLOTS = (EXTRA_CHAR_SLOTS < 4) ? EXTRA_CHAR_SLOTS : 4;

	// Configuration port.
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;

	// Register map of the configuration port.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SPACE_CHARS = CFG_IDX_W'(0),
		CFG_SPACE_COUNT = CFG_IDX_W'(1),
		CFG_DELIM_CHARS = CFG_IDX_W'(2),
		CFG_DELIM_COUNT = CFG_IDX_W'(3)
	} cfg_reg_t;

	// Queue between the front and back parts (power of two).
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	// Results one input character can cause.
	localparam int MAX_RES = 3;

	typedef struct packed {
		logic       kind;   // 0 token character, 1 token end
		logic [7:0] value;
		logic       empty;
		logic       trunc;
		logic       done;   // closes the line
	} res_t;

	typedef struct packed {
		logic [1:0]              cnt;   // number of valid slots, 1 to 3
		res_t [MAX_RES-1:0]      slot;
	} entry_t;

	typedef struct packed {
		logic   valid;
		entry_t entry;
	} push_t;

	typedef struct packed {
		logic   valid;
		entry_t entry;
	} head_t;

endpackage
`default_nettype wire

// ===== rtl/qts_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Input channel
// Valid/ready channel carrying one character of the command line.
// ----------------------------------------------------------------------------
interface qts_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_char;
	logic       line_end;

	modport source (output valid, output in_char, output line_end, input ready);
	modport sink (input valid, input in_char, input line_end, output ready);
endinterface
`default_nettype wire

// ===== rtl/qts_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Output channel
// Valid/ready channel carrying one token character or token end.
// ----------------------------------------------------------------------------
interface qts_out_if;
	logic       valid;
	logic       ready;
	logic       result_kind;
	logic [7:0] char_value;
	logic       token_empty;
	logic       token_truncated;
	logic       line_done;
	logic       last_of_run;

	modport source (output valid, output result_kind, output char_value,
		output token_empty, output token_truncated, output line_done,
		output last_of_run, input ready);
	modport sink (input valid, input result_kind, input char_value,
		input token_empty, input token_truncated, input line_done,
		input last_of_run, output ready);
endinterface
`default_nettype wire

// ===== rtl/qts_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Quoted token splitter front part
// Holds the configuration and scan state, classifies each character and
// builds the group of results it causes.
// ----------------------------------------------------------------------------
module qts_front import qts_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	qts_in_if.sink                     in_ch,
	input  wire logic                  q_full,
	output push_t                      push
);

	localparam logic [7:0] CH_BSLASH = 8'd92;
	localparam logic [7:0] CH_DQUOTE = 8'd34;
	localparam logic [7:0] CH_SQUOTE = 8'd39;
	localparam logic [7:0] CH_BQUOTE = 8'd96;
	localparam logic [7:0] CH_SPACE  = 8'd32;
	localparam logic [7:0] CH_TAB    = 8'd9;
	localparam logic [7:0] CH_CR     = 8'd13;

	typedef enum logic [5:0] {
		M_SKIP      = 6'b000001,
		M_TOKEN     = 6'b000010,
		M_TOKEN_ESC = 6'b000100,
		M_QUOTE     = 6'b001000,
		M_QUOTE_ESC = 6'b010000,
		M_TRAIL     = 6'b100000
	} mode_t;

	typedef struct packed {
		mode_t              mode;
		logic [7:0]         oq;
		logic [7:0]         held;
		logic [LEN_W-1:0]   len;
		logic               drp;
		logic [1:0]         n;
		res_t [MAX_RES-1:0] s;
	} wk_t;

	logic [31:0] space_chars_q;
	logic [2:0]  space_count_q;
	logic [31:0] delim_chars_q;
	logic [2:0]  delim_count_q;

	mode_t            mode_q;
	logic [7:0]       oq_q;
	logic [7:0]       held_q;
	logic [LEN_W-1:0] len_q;
	logic             drp_q;

	logic       accept;
	logic       is_sp;
	logic       is_dl;
	logic [7:0] c;
	logic       le;
	wk_t        w;

	function automatic logic in_set(logic [31:0] chars, logic [2:0] cnt, logic [7:0] ch);
		logic hit;
		hit = 1'b0;
		for (int i = 0; i < MATCH_SLOTS; i++) begin
			if ((int'(cnt) > i) && (chars[8*i +: 8] != 8'd0) && (chars[8*i +: 8] == ch)) begin
				hit = 1'b1;
			end
		end
		return hit;
	endfunction

	function automatic wk_t f_char(wk_t wi, logic [7:0] ch);
		wk_t r;
		r = wi;
		if (wi.len < LEN_W'(TOKEN_LIMIT - 1)) begin
			r.s[wi.n] = res_t'{1'b0, ch, 1'b0, 1'b0, 1'b0};
			r.n = wi.n + 2'd1;
			r.len = wi.len + LEN_W'(1);
		end else begin
			r.drp = 1'b1;
		end
		return r;
	endfunction

	function automatic wk_t f_end(wk_t wi, logic [7:0] ch);
		wk_t r;
		r = wi;
		r.s[wi.n] = res_t'{1'b1, ch, (wi.len == '0), wi.drp, 1'b0};
		r.n = wi.n + 2'd1;
		r.len = '0;
		r.drp = 1'b0;
		return r;
	endfunction

	// A character that starts or continues a token.
	function automatic wk_t f_tok(wk_t wi, logic [7:0] ch, logic lend);
		wk_t r;
		r = wi;
		if ((ch == CH_DQUOTE) || (ch == CH_SQUOTE) || (ch == CH_BQUOTE)) begin
			r.oq = ch;
			r.mode = M_QUOTE;
		end else if ((ch == CH_BSLASH) && !lend) begin
			r.mode = M_TOKEN_ESC;
		end else begin
			r = f_char(wi, ch);
			r.mode = M_TOKEN;
		end
		return r;
	endfunction

	assign c = in_ch.in_char;
	assign le = in_ch.line_end;
	assign in_ch.ready = !q_full;
	assign accept = in_ch.valid && !q_full;

	assign is_sp = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR)) ||
		in_set(space_chars_q, space_count_q, c);
	assign is_dl = in_set(delim_chars_q, delim_count_q, c);

	always_comb begin
		w.mode = mode_q;
		w.oq   = oq_q;
		w.held = held_q;
		w.len  = len_q;
		w.drp  = drp_q;
		w.n    = 2'd0;
		w.s    = '0;
		case (mode_q)
			M_SKIP: begin
				if (is_sp) begin
					w.mode = M_SKIP;
				end else if (is_dl) begin
					w = f_end(w, c);
				end else begin
					w = f_tok(w, c, le);
				end
			end
			M_TOKEN: begin
				if (is_sp) begin
					w.held = c;
					w.mode = M_TRAIL;
				end else if (is_dl) begin
					w = f_end(w, c);
					w.mode = M_SKIP;
				end else begin
					w = f_tok(w, c, le);
				end
			end
			M_TOKEN_ESC: begin
				w = f_char(w, c);
				w.mode = M_TOKEN;
			end
			M_QUOTE: begin
				if (c == oq_q) begin
					w.mode = M_TOKEN;
				end else if ((c == CH_BSLASH) && !le) begin
					w.mode = M_QUOTE_ESC;
				end else begin
					w = f_char(w, c);
				end
			end
			M_QUOTE_ESC: begin
				w = f_char(w, c);
				w.mode = M_QUOTE;
			end
			M_TRAIL: begin
				if (is_sp) begin
					w.mode = M_TRAIL;
				end else if (is_dl) begin
					w = f_end(w, c);
					w.mode = M_SKIP;
				end else begin
					w = f_end(w, held_q);
					w.mode = M_SKIP;
					w = f_tok(w, c, le);
				end
			end
			default: begin
				w.mode = M_SKIP;
			end
		endcase

		if (le) begin
			if (w.mode == M_SKIP) begin
				if (w.n == 2'd0) begin
					w = f_end(w, 8'd0);
				end
			end else if (w.mode == M_TRAIL) begin
				w = f_end(w, w.held);
			end else begin
				w = f_end(w, 8'd0);
			end
			w.s[w.n - 2'd1].done = 1'b1;
			w.mode = M_SKIP;
			w.oq   = 8'd0;
			w.held = 8'd0;
			w.len  = '0;
			w.drp  = 1'b0;
		end
	end

	assign push.valid = accept && (w.n != 2'd0);
	assign push.entry.cnt = w.n;
	assign push.entry.slot = w.s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			space_chars_q <= '0;
			space_count_q <= '0;
			delim_chars_q <= '0;
			delim_count_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_SPACE_CHARS: space_chars_q <= cfg_data[31:0];
				CFG_SPACE_COUNT: space_count_q <= cfg_data[2:0];
				CFG_DELIM_CHARS: delim_chars_q <= cfg_data[31:0];
				CFG_DELIM_COUNT: delim_count_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_SKIP;
			oq_q   <= '0;
			held_q <= '0;
			len_q  <= '0;
			drp_q  <= 1'b0;
		end else if (accept) begin
			mode_q <= w.mode;
			oq_q   <= w.oq;
			held_q <= w.held;
			len_q  <= w.len;
			drp_q  <= w.drp;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/qts_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Quoted token splitter queue
// Short queue of result groups between the front and back parts.
// ----------------------------------------------------------------------------
module qts_queue import qts_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire push_t push,
	input  wire logic  pop,
	output logic       full,
	output head_t      head
);

	entry_t            mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   cnt_q;
	logic              do_push;
	logic              do_pop;

	assign full = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign head.valid = (cnt_q != '0);
	assign head.entry = mem_q[rd_ptr_q];

	assign do_push = push.valid && !full;
	assign do_pop = pop && head.valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + (QPTR_W+1)'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - (QPTR_W+1)'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/qts_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Quoted token splitter back part
// Sends the results of each queued group one at a time through an
// output register.
// ----------------------------------------------------------------------------
module qts_back import qts_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire head_t head,
	output logic       pop,
	qts_out_if.source  out_ch
);

	logic       out_valid_q;
	res_t       res_q;
	logic       last_q;
	logic [1:0] idx_q;
	logic       ld;
	logic       last;

	assign ld = !out_valid_q || out_ch.ready;
	assign last = (idx_q == (head.entry.cnt - 2'd1));
	assign pop = ld && head.valid && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (ld) begin
			out_valid_q <= head.valid;
			if (head.valid) begin
				idx_q <= last ? 2'd0 : (idx_q + 2'd1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld && head.valid) begin
			res_q  <= head.entry.slot[idx_q];
			last_q <= last;
		end
	end

	assign out_ch.valid           = out_valid_q;
	assign out_ch.result_kind     = res_q.kind;
	assign out_ch.char_value      = res_q.value;
	assign out_ch.token_empty     = res_q.empty;
	assign out_ch.token_truncated = res_q.trunc;
	assign out_ch.line_done       = res_q.done;
	assign out_ch.last_of_run     = last_q;

endmodule
`default_nettype wire

// ===== rtl/quoted_token_splitter_unit.sv =====
// Each result group is queued as its character is accepted, then sent from the
// output register. Throughput: one character per cycle while the four-group
// queue has room; the output sends one result per cycle while the receiver
// is ready, so a character causing several results holds it until all are
// sent. Reset (arst_n low, asynchronous) clears the configuration, scan
// state, queue and output valid; there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Quoted token splitter
// Cuts a command line, one character per request, into tokens with quote
// spans, backslash escapes, extra space and delimiter characters.
// ----------------------------------------------------------------------------
module quoted_token_splitter_unit import qts_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	qts_in_if.sink                     in_ch,
	qts_out_if.source                  out_ch
);

	// The front part accepts a character whenever the queue has room. It
	// classifies the character against the whitespace set, the extra space
	// slots, the delimiter slots and the quote characters, steps the scan
	// state and builds the whole group of results (up to three) the
	// character causes. Characters that cause nothing leave no entry.
	push_t push;
	logic  q_full;

	// The queue holds result groups so that a stalled output does not stop
	// the input until the queue fills.
	head_t head;
	logic  pop;

	qts_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.q_full    (q_full),
		.push      (push)
	);

	qts_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.full   (q_full),
		.head   (head)
	);

	// The back part walks the slots of the head group and loads each result
	// into the output register; the group leaves the queue with its last
	// result, which also carries the end-of-run mark.
	qts_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.out_ch (out_ch)
	);

endmodule
`default_nettype wire

// ===== rtl/qts_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Quoted token splitter checker
// Watches the output port of the splitter for result rules.
// ----------------------------------------------------------------------------
`include "quoted_token_splitter_unit_assert.svh"

module qts_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic       result_kind,
	input wire logic [7:0] char_value,
	input wire logic       token_empty,
	input wire logic       token_truncated,
	input wire logic       line_done,
	input wire logic       last_of_run
);

	// A stalled result stays offered unchanged.
	`QTS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(char_value) && $stable(result_kind))

	// The result closing a line is always the last of its run.
	`QTS_ASSERT_SAME(a_done_last, clk, arst_n, out_valid && line_done, last_of_run && result_kind)

	// Token characters carry no end flags.
	`QTS_ASSERT_SAME(a_char_flags, clk, arst_n, out_valid && !result_kind, !token_empty && !token_truncated)

	// A truncated token cannot be empty.
	`QTS_ASSERT_SAME(a_trunc_nonempty, clk, arst_n, out_valid && token_truncated, !token_empty)

endmodule

bind quoted_token_splitter_unit qts_checker u_qts_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_ch.valid),
	.out_ready       (out_ch.ready),
	.result_kind     (out_ch.result_kind),
	.char_value      (out_ch.char_value),
	.token_empty     (out_ch.token_empty),
	.token_truncated (out_ch.token_truncated),
	.line_done       (out_ch.line_done),
	.last_of_run     (out_ch.last_of_run)
);
`default_nettype wire

// ===== dv/quoted_token_splitter_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quoted token splitter testbench
// Feeds command lines one character per request and checks every token
// character and token end against a scoreboard that tracks the scan state.
// The testbench covers directed corner cases and random lines under several
// separator settings, with random idling on both sides.
// ----------------------------------------------------------------------------
module quoted_token_splitter_unit_test;
	import qts_pkg::*;

	// Scanner modes of the tokenizer, as the scoreboard tracks them.
	typedef enum logic [2:0] {
		SCAN_SKIP,
		SCAN_TOKEN,
		SCAN_TOKEN_ESC,
		SCAN_QUOTE,
		SCAN_QUOTE_ESC,
		SCAN_TRAIL
	} scan_mode_t;

	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_END  = 1'b1;

	localparam logic [7:0] CHAR_NUL       = 8'h00;
	localparam logic [7:0] CHAR_TAB       = 8'h09;
	localparam logic [7:0] CHAR_CR        = 8'h0D;
	localparam logic [7:0] CHAR_SPACE     = 8'h20;
	localparam logic [7:0] CHAR_DQUOTE    = 8'h22;
	localparam logic [7:0] CHAR_SQUOTE    = 8'h27;
	localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
	localparam logic [7:0] CHAR_BACKTICK  = 8'h60;
	localparam logic [7:0] CHAR_MAX       = 8'hFF;

	// Cycles without any accepted request on either channel before giving up.
	localparam int WATCHDOG_LIMIT = 1000;
	// Length of the long receiver hold-off that makes the block back up.
	localparam int LONG_HOLD = 120;

	// One result as it leaves the block.
	typedef struct packed {
		logic       kind;
		logic [7:0] value;
		logic       empty;
		logic       trunc;
		logic       done;
		logic       last;
	} token_result_t;

	// Directed lines under the directed separator setting, {line_end, char}.
	// Underscore and semicolon are extra spaces, the bar, semicolon, equals
	// sign and ampersand are delimiters, and the delimiter count is above the
	// number of slots.
	localparam logic [8:0] DIRECTED [28] = '{
		{1'b0, "|"},            // delimiter before any token
		{1'b0, "a"},
		{1'b0, CHAR_DQUOTE},    // quote inside a token opens a span
		{1'b0, CHAR_SPACE},     // space inside the span is text
		{1'b0, "|"},            // so is a delimiter
		{1'b0, CHAR_DQUOTE},
		{1'b0, CHAR_BACKSLASH}, // escaped delimiter
		{1'b0, "|"},
		{1'b0, CHAR_NUL},       // zero is a plain character
		{1'b0, CHAR_SPACE},     // space ends the token, end held back
		{1'b0, "_"},            // extra space keeps waiting
		{1'b0, "="},            // delimiter after spaces is absorbed
		{1'b0, "b"},
		{1'b0, ";"},            // in both sets, acts as a space
		{1'b0, "c"},            // releases the held end with the semicolon
		{1'b0, CHAR_SQUOTE},
		{1'b0, "x"},
		{1'b1, CHAR_BACKSLASH}, // literal at line end, unclosed quote
		{1'b1, CHAR_SPACE},     // line of nothing closes with an empty end
		{1'b0, "k"},
		{1'b0, CHAR_BACKTICK},
		{1'b0, CHAR_BACKSLASH}, // escape inside a span
		{1'b0, CHAR_BACKTICK},
		{1'b0, CHAR_MAX},       // slot three is beyond the space count
		{1'b1, CHAR_BACKSLASH}, // literal backslash ends an open token
		{1'b0, "d"},
		{1'b1, CHAR_SPACE},     // held end closes the line
		{1'b1, "&"}             // delimiter alone at line end
	};

	// Scoreboard: tracks the scan state and holds the results still due.
	class token_scoreboard;
		logic [31:0]   space_set;
		logic [2:0]    space_used;
		logic [31:0]   delim_set;
		logic [2:0]    delim_used;
		scan_mode_t    mode;
		logic [7:0]    quote_char;
		logic [7:0]    held_space;
		int unsigned   token_len;
		logic          dropped;
		token_result_t step_results[$];
		token_result_t expected_q[$];
		int            errors;

		function new();
			space_set = '0;
			space_used = '0;
			delim_set = '0;
			delim_used = '0;
			errors = 0;
			clear_scan();
		endfunction

		function void clear_scan();
			mode = SCAN_SKIP;
			quote_char = CHAR_NUL;
			held_space = CHAR_NUL;
			token_len = 0;
			dropped = 1'b0;
		endfunction

		function void write_register(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
			CFG_SPACE_CHARS: space_set = data;
			CFG_SPACE_COUNT: space_used = data[2:0];
			CFG_DELIM_CHARS: delim_set = data;
			default: delim_used = data[2:0];
			endcase
		endfunction

		function bit in_slots(logic [31:0] chars, logic [2:0] used, logic [7:0] c);
			int n;
			n = (used < EXTRA_CHAR_SLOTS) ? used : EXTRA_CHAR_SLOTS;
			for (int i = 0; i < n && i < 4; i++)
				if (chars[8*i +: 8] != CHAR_NUL && chars[8*i +: 8] == c)
					return 1'b1;
			return 1'b0;
		endfunction

		function bit is_blank(logic [7:0] c);
			return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR) ||
				in_slots(space_set, space_used, c);
		endfunction

		function bit is_delim(logic [7:0] c);
			return in_slots(delim_set, delim_used, c);
		endfunction

		function void put(logic kind, logic [7:0] value, logic empty, logic trunc);
			token_result_t r;
			r.kind = kind;
			r.value = value;
			r.empty = empty;
			r.trunc = trunc;
			r.done = 1'b0;
			r.last = 1'b0;
			if (step_results.size() < MAX_RES)
				step_results.push_back(r);
		endfunction

		function void add_char(logic [7:0] c);
			if (token_len < TOKEN_LIMIT - 1) begin
				put(KIND_CHAR, c, 1'b0, 1'b0);
				token_len++;
			end else begin
				dropped = 1'b1;
			end
		endfunction

		function void add_end(logic [7:0] c);
			put(KIND_END, c, token_len == 0, dropped);
			token_len = 0;
			dropped = 1'b0;
		endfunction

		// A character that is neither space nor delimiter, in or at a token.
		function void start_char(logic [7:0] c, logic le);
			if (c == CHAR_DQUOTE || c == CHAR_SQUOTE || c == CHAR_BACKTICK) begin
				quote_char = c;
				mode = SCAN_QUOTE;
			end else if (c == CHAR_BACKSLASH && !le) begin
				mode = SCAN_TOKEN_ESC;
			end else begin
				add_char(c);
				mode = SCAN_TOKEN;
			end
		endfunction

		function void note_request(logic [7:0] c, logic le);
			step_results.delete();
			case (mode)
			SCAN_SKIP: begin
				if (!is_blank(c)) begin
					if (is_delim(c))
						add_end(c);
					else
						start_char(c, le);
				end
			end
			SCAN_TOKEN: begin
				if (is_blank(c)) begin
					held_space = c;
					mode = SCAN_TRAIL;
				end else if (is_delim(c)) begin
					add_end(c);
					mode = SCAN_SKIP;
				end else begin
					start_char(c, le);
				end
			end
			SCAN_TOKEN_ESC: begin
				add_char(c);
				mode = SCAN_TOKEN;
			end
			SCAN_QUOTE: begin
				if (c == quote_char)
					mode = SCAN_TOKEN;
				else if (c == CHAR_BACKSLASH && !le)
					mode = SCAN_QUOTE_ESC;
				else
					add_char(c);
			end
			SCAN_QUOTE_ESC: begin
				add_char(c);
				mode = SCAN_QUOTE;
			end
			default: begin
				if (!is_blank(c)) begin
					if (is_delim(c)) begin
						add_end(c);
						mode = SCAN_SKIP;
					end else begin
						add_end(held_space);
						mode = SCAN_SKIP;
						start_char(c, le);
					end
				end
			end
			endcase
			if (le) begin
				if (mode == SCAN_SKIP) begin
					if (step_results.size() == 0)
						add_end(CHAR_NUL);
				end else if (mode == SCAN_TRAIL) begin
					add_end(held_space);
				end else begin
					add_end(CHAR_NUL);
				end
				step_results[step_results.size() - 1].done = 1'b1;
				clear_scan();
			end
			if (step_results.size() > 0)
				step_results[step_results.size() - 1].last = 1'b1;
			foreach (step_results[i])
				expected_q.push_back(step_results[i]);
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		task report(string what);
			$display("%0t ERROR %s", $time, what);
			errors++;
		endtask

		task compare_field(string name, int got, int want);
			if (got != want)
				report($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, want));
		endtask

		task check_result(token_result_t got);
			token_result_t want;
			if (expected_q.size() == 0) begin
				report($sformatf("result with nothing outstanding: %p", got));
			end else begin
				want = expected_q.pop_front();
				compare_field("result_kind", got.kind, want.kind);
				compare_field("char_value", got.value, want.value);
				compare_field("token_empty", got.empty, want.empty);
				compare_field("token_truncated", got.trunc, want.trunc);
				compare_field("line_done", got.done, want.done);
				compare_field("last_of_run", got.last, want.last);
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	qts_in_if in_ch();
	qts_out_if out_ch();

	quoted_token_splitter_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	always #1 clk = ~clk;

	token_scoreboard sb;
	logic [7:0] line_chars[$];   // the line about to be sent
	int unsigned burst_left;     // requests left in the current sender burst
	int unsigned items_sent;
	int unsigned quiet_cycles;
	int unsigned hold_requests;  // bumped by the stimulus to ask for a long hold
	int unsigned holds_served;
	int unsigned hold_left;
	int unsigned rx_cycles;
	int unsigned rx_style;

	// Both channels are sampled right at the rising edge, before any of the
	// nonblocking updates of that edge land, so what is seen here is exactly
	// what the block saw. The same block runs the watchdog: if neither side
	// moves for too long, the run is declared failed.
	always @(posedge clk) begin : monitor
		token_result_t seen;
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready)
				sb.note_request(in_ch.in_char, in_ch.line_end);
			if (out_ch.valid && out_ch.ready) begin
				seen.kind = out_ch.result_kind;
				seen.value = out_ch.char_value;
				seen.empty = out_ch.token_empty;
				seen.trunc = out_ch.token_truncated;
				seen.done = out_ch.line_done;
				seen.last = out_ch.last_of_run;
				sb.check_result(seen);
			end
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// The receiver switches between stall styles, picked at random: always
	// ready, coin flip, one cycle in four, and mostly ready. When the stimulus
	// asks for it, it holds off for a long stretch so that the internal queue
	// fills and the input side has to stall.
	always @(posedge clk) begin
		if (hold_requests != holds_served) begin
			holds_served = hold_requests;
			hold_left = LONG_HOLD;
		end
		rx_cycles++;
		if (rx_cycles % 50 == 0)
			rx_style = $urandom_range(0, 3);
		if (hold_left > 0) begin
			hold_left--;
			out_ch.ready <= 1'b0;
		end else begin
			case (rx_style)
			0: out_ch.ready <= 1'b1;
			1: out_ch.ready <= 1'($urandom_range(0, 1));
			2: out_ch.ready <= (rx_cycles % 4 == 0);
			default: out_ch.ready <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	// Sends one request and returns once it has been accepted. The sender
	// works in bursts; between bursts it may drop valid for a random gap.
	// A quarter of the bursts follow on with no gap at all, so long runs at
	// full rate happen too.
	task automatic send_request(input logic [7:0] c, input logic le);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				in_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
		burst_left--;
		in_ch.valid <= 1'b1;
		in_ch.in_char <= c;
		in_ch.line_end <= le;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic send_line();
		foreach (line_chars[i])
			send_request(line_chars[i], i == line_chars.size() - 1);
	endtask

	// Every line ends on a character that yields a result, so once nothing is
	// outstanding the block is idle, and the task then lets the pipeline settle.
	// The first edge lets the monitor note the last accepted request.
	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Writes all four registers on consecutive edges; only called when idle.
	task automatic program_sets(input logic [31:0] spaces, input logic [2:0] nspace,
			input logic [31:0] delims, input logic [2:0] ndelim);
		logic [CFG_DATA_W-1:0] vals [4];
		cfg_reg_t r;
		vals = '{spaces, 32'(nspace), delims, 32'(ndelim)};
		for (int i = 0; i < 4; i++) begin
			r = cfg_reg_t'(i);
			cfg_wr_en <= 1'b1;
			cfg_index <= r;
			cfg_data <= vals[i];
			sb.write_register(r, vals[i]);
			@(posedge clk);
		end
		cfg_wr_en <= 1'b0;
	endtask

	// Slot contents lean on punctuation, with zero bytes, quotes and any
	// byte at all mixed in.
	function automatic logic [31:0] random_slots();
		logic [31:0] v;
		for (int i = 0; i < 4; i++) begin
			case ($urandom_range(0, 7))
			0: v[8*i +: 8] = ",";
			1: v[8*i +: 8] = ";";
			2: v[8*i +: 8] = "|";
			3: v[8*i +: 8] = ":";
			4: v[8*i +: 8] = CHAR_NUL;
			5: v[8*i +: 8] = CHAR_DQUOTE;
			6: v[8*i +: 8] = "#";
			default: v[8*i +: 8] = 8'($urandom_range(1, 255));
			endcase
		end
		return v;
	endfunction

	// Character pickers for line building. Configured characters are taken
	// from the slots in use, with a plain fallback when a slot is idle.
	function automatic logic [7:0] pick_blank();
		int unsigned slot;
		slot = $urandom_range(0, 3);
		case ($urandom_range(0, 5))
		0: return CHAR_TAB + 8'($urandom_range(0, 4));
		1, 2: begin
			if (slot < sb.space_used && sb.space_set[8*slot +: 8] != CHAR_NUL)
				return sb.space_set[8*slot +: 8];
			return CHAR_SPACE;
		end
		default: return CHAR_SPACE;
		endcase
	endfunction

	function automatic logic [7:0] pick_delim();
		int unsigned slot;
		slot = $urandom_range(0, 3);
		if (slot < sb.delim_used && sb.delim_set[8*slot +: 8] != CHAR_NUL)
			return sb.delim_set[8*slot +: 8];
		return pick_blank();
	endfunction

	function automatic logic [7:0] pick_quote();
		case ($urandom_range(0, 2))
		0: return CHAR_DQUOTE;
		1: return CHAR_SQUOTE;
		default: return CHAR_BACKTICK;
		endcase
	endfunction

	function automatic logic [7:0] pick_text();
		case ($urandom_range(0, 7))
		0: return 8'($urandom_range(0, 255));
		1: return "0" + 8'($urandom_range(0, 9));
		2: return "A" + 8'($urandom_range(0, 25));
		default: return "a" + 8'($urandom_range(0, 25));
		endcase
	endfunction

	function automatic logic [7:0] pick_any();
		case ($urandom_range(0, 7))
		0, 1: return pick_blank();
		2: return pick_delim();
		3: return pick_quote();
		4: return CHAR_BACKSLASH;
		default: return pick_text();
		endcase
	endfunction

	// A tidy line is a few tokens made of words, quoted spans and escapes,
	// separated by spaces and delimiters; its tail may leave a quote open or
	// end on a backslash. An untidy line is a short run of anything.
	function automatic void build_line(bit tidy);
		int unsigned len;
		logic [7:0] q;
		line_chars.delete();
		if (!tidy) begin
			len = $urandom_range(1, 10);
			repeat (len) line_chars.push_back(pick_any());
			return;
		end
		repeat ($urandom_range(1, 4)) begin
			if ($urandom_range(0, 2) == 0)
				line_chars.push_back(pick_blank());
			len = $urandom_range(1, 5);
			repeat (len) begin
				case ($urandom_range(0, 9))
				0: begin
					q = pick_quote();
					line_chars.push_back(q);
					repeat ($urandom_range(0, 4)) line_chars.push_back(pick_any());
					line_chars.push_back(q);
				end
				1: begin
					line_chars.push_back(CHAR_BACKSLASH);
					line_chars.push_back(pick_any());
				end
				default: line_chars.push_back(pick_text());
				endcase
			end
			case ($urandom_range(0, 3))
			0: line_chars.push_back(pick_blank());
			1: line_chars.push_back(pick_delim());
			2: begin
				line_chars.push_back(pick_blank());
				line_chars.push_back(pick_delim());
				line_chars.push_back(pick_blank());
			end
			default: begin
				line_chars.push_back(pick_blank());
				line_chars.push_back(pick_blank());
			end
			endcase
		end
		case ($urandom_range(0, 5))
		0: begin
			line_chars.push_back(pick_quote());
			line_chars.push_back(pick_text());
		end
		1: line_chars.push_back(CHAR_BACKSLASH);
		2, 3: line_chars.pop_back();
		default: ;
		endcase
	endfunction

	initial begin
		int unsigned first;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.in_char = '0;
		in_ch.line_end = 1'b0;
		out_ch.ready = 1'b0;
		burst_left = 0;
		items_sent = 0;
		quiet_cycles = 0;
		hold_requests = 0;
		holds_served = 0;
		hold_left = 0;
		rx_cycles = 0;
		rx_style = 0;
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// With the reset setting the bar is plain text: a token, a space and a
		// character at line end give the most results one request can cause.
		send_request("a", 1'b0);
		send_request(CHAR_SPACE, 1'b0);
		send_request("|", 1'b1);
		wait_drained();

		// Directed corner cases. A zero byte sits in one space slot, slot
		// three lies beyond the space count, the semicolon is in both sets,
		// and the delimiter count exceeds the slots.
		program_sets({CHAR_MAX, ";", CHAR_NUL, "_"}, 3'd3, {"&", "=", ";", "|"}, 3'd7);
		foreach (DIRECTED[i])
			send_request(DIRECTED[i][7:0], DIRECTED[i][8]);
		wait_drained();

		// Random lines under several settings: nothing configured, every slot
		// at the top byte value, then random slots and counts. The third
		// setting also gets the long receiver hold-off.
		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
			0: program_sets('0, 3'd0, '0, 3'd0);
			1: program_sets('1, 3'd4, '1, 3'd4);
			3: program_sets(random_slots(), 3'd4, random_slots(), 3'd4);
			default: program_sets(random_slots(), 3'($urandom_range(0, 4)),
				random_slots(), 3'($urandom_range(0, 4)));
			endcase
			if (phase == 2)
				hold_requests++;
			first = items_sent;
			while (items_sent - first < 44) begin
				build_line($urandom_range(0, 4) != 0);
				send_line();
			end
			wait_drained();
		end

		// Anything that still shows up now has no expectation behind it.
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/qts_pkg.sv
rtl/qts_in_if.sv
rtl/qts_out_if.sv
rtl/qts_front.sv
rtl/qts_queue.sv
rtl/qts_back.sv
rtl/quoted_token_splitter_unit.sv
rtl/qts_checker.sv
dv/quoted_token_splitter_unit_test.sv
